// ===== rtl/nrmc_pkg.sv =====
// types, character codes and constant tables shared by the rmc position parser
package nrmc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SOUTH  = 8'h53;
  localparam logic [7:0] CH_WEST   = 8'h57;

  localparam logic [2:0] HDR_LAST_POS = 3'd5;
  localparam logic [2:0] HDR_LEN      = 3'd6;

  localparam logic [3:0] FLD_FIRST = 4'd1;
  localparam logic [3:0] FLD_LAT   = 4'd3;
  localparam logic [3:0] FLD_NS    = 4'd4;
  localparam logic [3:0] FLD_LON   = 4'd5;
  localparam logic [3:0] FLD_EW    = 4'd6;

  localparam logic [3:0] LAT_DEG_CHARS = 4'd2;
  localparam logic [3:0] LON_DEG_CHARS = 4'd3;

  localparam logic [31:0] LAT_LIMIT = 32'd900000000;
  localparam logic [31:0] LON_LIMIT = 32'd1800000000;

  typedef struct packed {
    logic [7:0]  deg;
    logic [6:0]  whole;
    logic [23:0] frac;
    logic [2:0]  cnt;
    logic        neg;
  } nrmc_num_t;

  typedef struct packed {
    nrmc_num_t lat;
    nrmc_num_t lon;
  } nrmc_launch_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h4E;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [23:0] pow10(input logic [2:0] e);
    logic [23:0] p;
    unique case (e)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      3'd7: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/nrmc_parser.sv =====
// per-byte sentence front end: header match, field count and number accumulators
module nrmc_parser #(
  parameter int unsigned FRAC_DIGITS = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_acc,
  input  logic [7:0]            byte_in,
  output logic                  launch_v,
  output nrmc_pkg::nrmc_launch_t launch
);

  logic [2:0]  hmp_r, hmp_nxt;
  logic        in_rmc_r, in_rmc_nxt;
  logic [3:0]  fi_r, fi_nxt;
  logic [3:0]  cif_r, cif_nxt;
  logic [7:0]  deg_r, deg_nxt;
  logic [6:0]  whole_r, whole_nxt;
  logic [23:0] frac_r, frac_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        seen_r, seen_nxt;
  nrmc_pkg::nrmc_num_t held_r, held_nxt;

  logic        digit;
  logic [3:0]  dval;
  logic [3:0]  deg_chars;
  logic [11:0] deg_calc;
  logic [10:0] whole_calc;
  logic [27:0] frac_calc;

  always_comb begin
    digit      = (byte_in >= nrmc_pkg::CH_ZERO) && (byte_in <= nrmc_pkg::CH_NINE);
    dval       = 4'(byte_in - nrmc_pkg::CH_ZERO);
    deg_chars  = (fi_r == nrmc_pkg::FLD_LAT) ? nrmc_pkg::LAT_DEG_CHARS
                                              : nrmc_pkg::LON_DEG_CHARS;
    deg_calc   = 12'(deg_r) * 12'd10 + 12'(dval);
    whole_calc = 11'(whole_r) * 11'd10 + 11'(dval);
    frac_calc  = 28'(frac_r) * 28'd10 + 28'(dval);

    hmp_nxt    = hmp_r;
    in_rmc_nxt = in_rmc_r;
    fi_nxt     = fi_r;
    cif_nxt    = cif_r;
    deg_nxt    = deg_r;
    whole_nxt  = whole_r;
    frac_nxt   = frac_r;
    cnt_nxt    = cnt_r;
    seen_nxt   = seen_r;
    held_nxt   = held_r;
    launch_v   = 1'b0;

    if (byte_acc) begin
      priority if (byte_in == nrmc_pkg::CH_DOLLAR) begin
        hmp_nxt    = 3'd1;
        in_rmc_nxt = 1'b0;
        fi_nxt     = '0;
        cif_nxt    = '0;
      end else if (byte_in == nrmc_pkg::CH_CR || byte_in == nrmc_pkg::CH_LF) begin
        hmp_nxt    = '0;
        in_rmc_nxt = 1'b0;
      end else if (!in_rmc_r) begin
        if (hmp_r >= 3'd1 && hmp_r <= nrmc_pkg::HDR_LAST_POS) begin
          hmp_nxt = (byte_in == nrmc_pkg::hdr_char(hmp_r)) ? hmp_r + 3'd1 : 3'd0;
        end else if (hmp_r == nrmc_pkg::HDR_LEN) begin
          hmp_nxt = '0;
          if (byte_in == nrmc_pkg::CH_COMMA) begin
            in_rmc_nxt = 1'b1;
            fi_nxt     = nrmc_pkg::FLD_FIRST;
            cif_nxt    = '0;
          end
        end else begin
          hmp_nxt = '0;
        end
      end else begin
        // latitude is frozen on the first byte of its hemisphere field
        if (fi_r == nrmc_pkg::FLD_NS && cif_r == 4'd0) begin
          held_nxt.deg   = deg_r;
          held_nxt.whole = whole_r;
          held_nxt.frac  = frac_r;
          held_nxt.cnt   = cnt_r;
          held_nxt.neg   = (byte_in == nrmc_pkg::CH_SOUTH);
        end
        if (fi_r == nrmc_pkg::FLD_EW && cif_r == 4'd0) begin
          launch_v   = 1'b1;
          in_rmc_nxt = 1'b0;
        end else if (byte_in == nrmc_pkg::CH_COMMA) begin
          fi_nxt  = (fi_r != 4'hF) ? fi_r + 4'd1 : fi_r;
          cif_nxt = '0;
          if (fi_nxt == nrmc_pkg::FLD_LAT || fi_nxt == nrmc_pkg::FLD_LON) begin
            deg_nxt   = '0;
            whole_nxt = '0;
            frac_nxt  = '0;
            cnt_nxt   = '0;
            seen_nxt  = 1'b0;
          end
        end else begin
          if (fi_r == nrmc_pkg::FLD_LAT || fi_r == nrmc_pkg::FLD_LON) begin
            priority if (cif_r < deg_chars) begin
              if (digit) begin
                deg_nxt = (deg_calc > 12'd255) ? 8'd255 : deg_calc[7:0];
              end
            end else if (byte_in == nrmc_pkg::CH_POINT) begin
              seen_nxt = 1'b1;
            end else begin
              if (digit) begin
                if (!seen_r) begin
                  whole_nxt = (whole_calc > 11'd127) ? 7'd127 : whole_calc[6:0];
                end else if (cnt_r < 3'(FRAC_DIGITS)) begin
                  frac_nxt = frac_calc[23:0];
                  cnt_nxt  = cnt_r + 3'd1;
                end
              end
            end
          end
          cif_nxt = (cif_r != 4'hF) ? cif_r + 4'd1 : cif_r;
        end
      end
    end

    launch.lat       = held_r;
    launch.lon.deg   = deg_r;
    launch.lon.whole = whole_r;
    launch.lon.frac  = frac_r;
    launch.lon.cnt   = cnt_r;
    launch.lon.neg   = (byte_in == nrmc_pkg::CH_WEST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmp_r    <= '0;
      in_rmc_r <= 1'b0;
      fi_r     <= '0;
      cif_r    <= '0;
      deg_r    <= '0;
      whole_r  <= '0;
      frac_r   <= '0;
      cnt_r    <= '0;
      seen_r   <= 1'b0;
    end else begin
      hmp_r    <= hmp_nxt;
      in_rmc_r <= in_rmc_nxt;
      fi_r     <= fi_nxt;
      cif_r    <= cif_nxt;
      deg_r    <= deg_nxt;
      whole_r  <= whole_nxt;
      frac_r   <= frac_nxt;
      cnt_r    <= cnt_nxt;
      seen_r   <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

// ===== rtl/nrmc_conv.sv =====
// one coordinate lane: degrees, minutes and fraction to signed 1e-7 degree
module nrmc_conv (
  input  logic                clk,
  input  logic [4:0]          en,
  input  nrmc_pkg::nrmc_num_t num_i,
  input  logic [31:0]         limit,
  output logic [31:0]         value_o
);

  localparam logic [31:0] DEG_SCALE  = 32'd10000000;
  localparam logic [24:0] WHOLE_STEP = 25'd166666;
  localparam logic [23:0] WHOLE_REM  = 24'd40;
  localparam logic [23:0] ROUND_ADD  = 24'd30;
  localparam logic [44:0] RECIP_15   = 45'd4473925;

  nrmc_pkg::nrmc_num_t s0_r;
  logic [23:0] x_r;
  logic [31:0] dm_r;
  logic [24:0] wm_r;
  logic [6:0]  whole1_r;
  logic        neg1_r;
  logic [23:0] z_r;
  logic [31:0] base2_r;
  logic        neg2_r;
  logic [18:0] q_r;
  logic [31:0] base3_r;
  logic        neg3_r;
  logic [31:0] val_r;

  logic [47:0] x_full;
  logic [31:0] dm;
  logic [24:0] wm;
  logic [23:0] z;
  logic [44:0] q_full;
  logic [31:0] sum;
  logic [31:0] mag;

  always_comb begin
    x_full = 48'(s0_r.frac) * 48'(nrmc_pkg::pow10(3'd7 - s0_r.cnt));
    dm     = 32'(s0_r.deg) * DEG_SCALE;
    wm     = 25'(s0_r.whole) * WHOLE_STEP;
    z      = 24'(whole1_r) * WHOLE_REM + x_r + ROUND_ADD;
    // divide by 60 as a shift by 2 then a reciprocal multiply by 1/15
    q_full = 45'(z_r[23:2]) * RECIP_15;
    sum    = base3_r + 32'(q_r);
    mag    = (sum > limit) ? limit : sum;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= num_i;
    end
    if (en[1]) begin
      x_r      <= x_full[23:0];
      dm_r     <= dm;
      wm_r     <= wm;
      whole1_r <= s0_r.whole;
      neg1_r   <= s0_r.neg;
    end
    if (en[2]) begin
      z_r     <= z;
      base2_r <= dm_r + 32'(wm_r);
      neg2_r  <= neg1_r;
    end
    if (en[3]) begin
      q_r     <= q_full[44:26];
      base3_r <= base2_r;
      neg3_r  <= neg2_r;
    end
    if (en[4]) begin
      val_r <= neg3_r ? (32'd0 - mag) : mag;
    end
  end

  assign value_o = val_r;

endmodule

// ===== rtl/nmea_rmc_position_parser.sv =====
// top level of the rmc position parser: byte front end, two lanes, result flow control
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: rx_byte
//  out_    | out | out_tvalid/out_tready| out_tdata: latitude_e7, longitude_e7, pad
//
//  one byte is taken every cycle while in_tready is high; the parser state updates
//  on the byte itself; a result leaves the output register once the hemisphere byte
//  that triggers it has passed the five-stage conversion pipeline of each lane
//  the pipeline holds up to five results; in_tready drops only when all are full
//  and out_tready is low
//  rst_n synchronous, clears every stage valid and the parser state except the held latitude
module nmea_rmc_position_parser #(
  parameter int unsigned FRAC_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [30:0] latitude_e7, [62:31] longitude_e7, [63] zero
);

  logic                   in_acc;
  logic                   launch_v;
  nrmc_pkg::nrmc_launch_t launch;
  logic [4:0]             v_r, v_nxt;
  logic [4:0]             rdy;
  logic [31:0]            lat_val;
  logic [31:0]            lon_val;

  assign in_acc = in_tvalid && in_tready;

  nrmc_parser #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_acc(in_acc),
    .byte_in (in_tdata),
    .launch_v(launch_v),
    .launch  (launch)
  );

  nrmc_conv u_lat (
    .clk    (clk),
    .en     (rdy),
    .num_i  (launch.lat),
    .limit  (nrmc_pkg::LAT_LIMIT),
    .value_o(lat_val)
  );

  nrmc_conv u_lon (
    .clk    (clk),
    .en     (rdy),
    .num_i  (launch.lon),
    .limit  (nrmc_pkg::LON_LIMIT),
    .value_o(lon_val)
  );

  always_comb begin
    rdy[4] = !v_r[4] || out_tready;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? launch_v : v_r[0];
    for (int k = 1; k < 5; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[4];
  assign out_tdata  = {1'b0, lon_val, lat_val[30:0]};

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_tready)
    else $error("input stalled with an empty first stage");

  a_launch_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[0]) |-> $past(in_tvalid && in_tready))
    else $error("result started without an accepted byte");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:0]) >= -31'sd900000000 &&
                    $signed(out_tdata[30:0]) <= 31'sd900000000))
    else $error("latitude out of range");

  a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[62:31]) >= -32'sd1800000000 &&
                    $signed(out_tdata[62:31]) <= 32'sd1800000000))
    else $error("longitude out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[4] && !out_tready) |=> v_r[4])
    else $error("stalled result dropped");

endmodule

// ===== test/tb_nmea_rmc_position_parser.sv =====
// testbench for the rmc position parser: directed sentences, random sentence stream, scoreboard
module tb_nmea_rmc_position_parser;

  localparam int FRAC_DIGITS  = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1100;
  localparam int HOLD_CYCLES  = 2000;

  typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC } rx_mode_t;

  typedef struct {
    string text;
    bit    typed;
    int    lat;
    int    lon;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;

  // parser shadow state
  logic [2:0]  p_hdr_pos;
  logic        p_in_rmc;
  logic [3:0]  p_field;
  logic [3:0]  p_char;
  logic [7:0]  p_deg;
  logic [6:0]  p_whole;
  logic [23:0] p_frac;
  logic [2:0]  p_frac_cnt;
  logic        p_seen_point;
  logic [31:0] p_held_lat;

  logic [63:0] fix_q[$];
  logic [7:0]  line_q[$];
  logic [63:0] want;
  string       rmc_header = "$GNRMC";
  int          failures;
  int          bytes_sent;
  int          burst_left;
  int          cycle_count;
  bit          hold_request;
  int          hold_left;
  rx_mode_t    rx_mode;
  int          rx_mode_left;
  int          rx_phase;

  dir_row_t dir_rows [0:14] = '{
    '{"$GNRMC,,,,,,,", 1'b1, 0, 0},
    '{"$GNRMC,123519,A,4807.038,N,01131.000,E,022.4\r\n", 1'b0, 0, 0},
    '{"$GNRMC,,,9999.99999,S,99999.99999,W\r\n", 1'b1, -900000000, -1800000000},
    '{"$GNRMC,,,9000.0,S,18000.0,W\r\n", 1'b1, -900000000, -1800000000},
    '{"$GNRMC,,,0000.00000,N,00000.00000,E\r\n", 1'b1, 0, 0},
    '{"$GNRMC,,,3345.1234567,S,11824.9876543,W\r\n", 1'b0, 0, 0},
    '{"$GNRMC,,,3x3y45.1.2,N,1a182.4.9,E\r\n", 1'b0, 0, 0},
    '{"$GNRMC,,,12345678901234567890,N,,E\r\n", 1'b0, 0, 0},
    '{"$GNRMC,,,4807.038,,01131.000,\r\n", 1'b0, 0, 0},
    '{"$GNRMC,,,4807.038,N,011$GNRMC,,,0100.0,S,00030.0,W\r\n", 1'b0, 0, 0},
    '{"$GNRMC,,,4807.038,N\r,01131.000,E\n", 1'b0, 0, 0},
    '{"$GPGGA,,,4807.038,N,01131.000,E\r\n", 1'b0, 0, 0},
    '{"$GNRMCX,,4807.038,N,01131.000,E\r\n", 1'b0, 0, 0},
    '{"$GNRMC,,,4807.038,s,01131.000,w\r\n", 1'b0, 0, 0},
    '{"$GNRMC,,,0030.00000,S,00000.00001,W*1F\r\n", 1'b0, 0, 0}
  };

  nmea_rmc_position_parser #(.FRAC_DIGITS(FRAC_DIGITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned ten_pow(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic logic [31:0] scaled_position(input logic [31:0] limit, input bit negate);
    int              cnt;
    longint unsigned scale;
    longint unsigned minutes;
    longint unsigned mag;
    cnt = p_frac_cnt;
    if (cnt > FRAC_DIGITS) cnt = FRAC_DIGITS;
    scale = ten_pow(FRAC_DIGITS);
    minutes = longint'(p_whole) * scale + longint'(p_frac) * ten_pow(FRAC_DIGITS - cnt);
    mag = longint'(p_deg) * 64'd10000000
        + (minutes * 64'd10000000 + 64'd30 * scale) / (64'd60 * scale);
    if (mag > limit) mag = limit;
    return negate ? 32'd0 - mag[31:0] : mag[31:0];
  endfunction

  task automatic clear_coord();
    p_deg = '0;
    p_whole = '0;
    p_frac = '0;
    p_frac_cnt = '0;
    p_seen_point = 1'b0;
  endtask

  task automatic take_coord_char(input logic [7:0] c, input logic [3:0] deg_chars);
    bit digit;
    int v;
    digit = (c >= nrmc_pkg::CH_ZERO && c <= nrmc_pkg::CH_NINE);
    if (p_char < deg_chars) begin
      if (digit) begin
        v = p_deg * 10 + (c - nrmc_pkg::CH_ZERO);
        p_deg = (v > 255) ? 8'd255 : v[7:0];
      end
    end else if (c == nrmc_pkg::CH_POINT) begin
      p_seen_point = 1'b1;
    end else if (digit) begin
      if (!p_seen_point) begin
        v = p_whole * 10 + (c - nrmc_pkg::CH_ZERO);
        p_whole = (v > 127) ? 7'd127 : v[6:0];
      end else if (p_frac_cnt < FRAC_DIGITS) begin
        p_frac = 24'(p_frac * 10 + (c - nrmc_pkg::CH_ZERO));
        p_frac_cnt++;
      end
    end
  endtask

  task automatic parse_rmc_byte(input logic [7:0] c, output bit got, output logic [63:0] word);
    logic [31:0] lon;
    bit          first;
    got = 1'b0;
    word = '0;
    if (c == nrmc_pkg::CH_DOLLAR) begin
      p_hdr_pos = 3'd1;
      p_in_rmc = 1'b0;
      p_field = '0;
      p_char = '0;
    end else if (c == nrmc_pkg::CH_CR || c == nrmc_pkg::CH_LF) begin
      p_hdr_pos = '0;
      p_in_rmc = 1'b0;
    end else if (!p_in_rmc) begin
      if (p_hdr_pos >= 3'd1 && p_hdr_pos <= nrmc_pkg::HDR_LAST_POS) begin
        if (c == rmc_header[p_hdr_pos]) p_hdr_pos++;
        else p_hdr_pos = '0;
      end else if (p_hdr_pos == nrmc_pkg::HDR_LEN) begin
        p_hdr_pos = '0;
        if (c == nrmc_pkg::CH_COMMA) begin
          p_in_rmc = 1'b1;
          p_field = nrmc_pkg::FLD_FIRST;
          p_char = '0;
        end
      end else begin
        p_hdr_pos = '0;
      end
    end else begin
      first = (p_char == 0);
      if (p_field == nrmc_pkg::FLD_NS && first) begin
        p_held_lat = scaled_position(nrmc_pkg::LAT_LIMIT, c == nrmc_pkg::CH_SOUTH);
      end
      if (p_field == nrmc_pkg::FLD_EW && first) begin
        lon = scaled_position(nrmc_pkg::LON_LIMIT, c == nrmc_pkg::CH_WEST);
        word = {1'b0, lon, p_held_lat[30:0]};
        got = 1'b1;
        p_in_rmc = 1'b0;
      end else if (c == nrmc_pkg::CH_COMMA) begin
        if (p_field < 4'd15) p_field++;
        p_char = '0;
        if (p_field == nrmc_pkg::FLD_LAT || p_field == nrmc_pkg::FLD_LON) clear_coord();
      end else begin
        if (p_field == nrmc_pkg::FLD_LAT) take_coord_char(c, nrmc_pkg::LAT_DEG_CHARS);
        else if (p_field == nrmc_pkg::FLD_LON) take_coord_char(c, nrmc_pkg::LON_DEG_CHARS);
        if (p_char < 4'd15) p_char++;
      end
    end
  endtask

  // bursts of back-to-back items with random gaps between them
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 30);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input logic [63:0] typed_word);
    bit          got;
    logic [63:0] word;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_rmc_byte(b, got, word);
    if (got) fix_q.push_back(typed ? typed_word : word);
    bytes_sent++;
    pace_sender();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) line_q.push_back(8'(nrmc_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic add_coord(input int deg_chars);
    string strays;
    int    n;
    strays = "x.A-+ :";
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, deg_chars + 1) : deg_chars;
    add_digits(n);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 2;
    add_digits(n);
    if ($urandom_range(0, 7) != 0) begin
      line_q.push_back(nrmc_pkg::CH_POINT);
      add_digits($urandom_range(0, FRAC_DIGITS + 2));
    end
    if ($urandom_range(0, 11) == 0) begin
      line_q.push_back(strays[$urandom_range(0, strays.len() - 1)]);
      add_digits($urandom_range(0, 3));
    end
  endtask

  task automatic add_hemisphere(input string pos_side, input string neg_side);
    int k;
    k = $urandom_range(0, 19);
    if (k < 9) add_text(pos_side);
    else if (k < 18) add_text(neg_side);
    else if (k == 18) add_text("");
    else if ($urandom_range(0, 1) != 0) add_text("s");
    else add_text("WX");
  endtask

  task automatic build_sentence();
    int k;
    line_q.delete();
    k = $urandom_range(0, 19);
    if (k < 17) add_text("$GNRMC");
    else if (k == 17) add_text("$GPRMC");
    else if (k == 18) add_text("$GNGGA");
    else add_text("$GNRMCC");
    add_text(",");
    add_digits($urandom_range(0, 6));
    add_text(",");
    if ($urandom_range(0, 3) != 0) add_text($urandom_range(0, 1) ? "A" : "V");
    add_text(",");
    add_coord(2);
    add_text(",");
    add_hemisphere("N", "S");
    add_text(",");
    add_coord(3);
    add_text(",");
    add_hemisphere("E", "W");
    if ($urandom_range(0, 2) == 0) add_text(",0.5,54.7,191194,020.3,E*68");
    add_text("\r\n");
    // broken sentences: one byte overwritten with a random value, or cut short
    if ($urandom_range(0, 9) == 0)
      line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
    else if ($urandom_range(0, 9) == 0)
      line_q = line_q[0:$urandom_range(0, line_q.size() - 1)];
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (fix_q.size() == 0) begin
        $error("unexpected item %h", out_tdata);
        failures++;
      end else begin
        want = fix_q.pop_front();
        if (out_tdata[30:0] !== want[30:0]) begin
          $error("latitude_e7 expected %0d actual %0d", $signed(want[30:0]),
                 $signed(out_tdata[30:0]));
          failures++;
        end
        if (out_tdata[62:31] !== want[62:31]) begin
          $error("longitude_e7 expected %0d actual %0d", $signed(want[62:31]),
                 $signed(out_tdata[62:31]));
          failures++;
        end
        if (out_tdata[63] !== 1'b0) begin
          $error("pad expected 0 actual %b", out_tdata[63]);
          failures++;
        end
      end
    end
  end

  // result side: changing stall patterns, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    rx_mode_left = 0;
    rx_phase = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      rx_phase++;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(50, 400);
        end
        rx_mode_left--;
        case (rx_mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= $urandom_range(0, 1);
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ((rx_phase % 5) < 3);
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int sentences;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    failures = 0;
    bytes_sent = 0;
    burst_left = 0;
    hold_request = 1'b0;
    sentences = 0;
    p_hdr_pos = '0;
    p_in_rmc = 1'b0;
    p_field = '0;
    p_char = '0;
    p_held_lat = '0;
    clear_coord();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].text.len(); i++)
        send_byte(dir_rows[r].text[i], dir_rows[r].typed,
                  {1'b0, dir_rows[r].lon[31:0], dir_rows[r].lat[30:0]});
    end

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        build_sentence();
        foreach (line_q[i]) send_byte(line_q[i], 1'b0, '0);
        sentences++;
        if (sentences == 6) hold_request = 1'b1;
      end
    end
    in_tvalid <= 1'b0;

    while (fix_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0 && fix_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nrmc_pkg.sv
rtl/nrmc_parser.sv
rtl/nrmc_conv.sv
rtl/nmea_rmc_position_parser.sv
test/tb_nmea_rmc_position_parser.sv
